/* hdl/cpd_pkg.sv */
`default_nettype none
package cpd_pkg;

   // Payload buffer geometry
   localparam int PAYLOAD_DEPTH = 1024;
   localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);
   localparam int LEN_W = 11;
   localparam int HDR_BYTES = 5;

   // CRC-16/Modbus
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Register reset values
   localparam logic [7:0] START_BYTE_RST = 8'hAA;
   localparam logic [15:0] TIMEOUT_RST = 16'd50;
   localparam logic [LEN_W-1:0] MAX_LEN_RST = LEN_W'(PAYLOAD_DEPTH);

   // Register indexes
   localparam logic [1:0] CSR_START_BYTE = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_MAX_LENGTH = 2'd2;

   // Input modes
   localparam logic [1:0] MODE_BYTE = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_GOOD = 2'd0;
   localparam logic [1:0] KIND_CRC_ERR = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   typedef enum logic [1:0] {
      PH_WAIT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_CRC     = 2'd3
   } phase_type;

   // Fold one byte into the CRC, LSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* hdl/cpd_ram.sv */
`default_nettype none
module cpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/crc16_packet_deframer.sv */
`default_nettype none
// Serial packet deframer with CRC-16/Modbus check.
//
// req_* carries one item per accepted cycle: mode 0 is a received serial byte
// (req_rx_byte), mode 1 is one time tick, mode 2 reads the payload byte at
// req_read_index, mode 3 is ignored. Frames are: start byte, target, sender,
// command, 16-bit length (LSB first), payload, CRC-16/Modbus (LSB first).
// rsp_* returns one item for the second CRC byte of a frame (kind 0 good,
// kind 1 CRC mismatch) and one for every read (kind 2). Other items give none.
// csr_* writes start_byte (0), timeout_ticks (1), max_length (2); always ready.
//
// A result passes from its accepted item through the middle stage (which covers
// the payload RAM registered read) and then the output register to rsp_valid.
// Throughput: one item per cycle while req_stall is low; bytes are folded into
// the CRC and written to the payload RAM in the cycle they are accepted.
// When rsp_stall holds the output register full, the next result waits in the
// middle stage and req_stall rises only once that stage is also occupied.
// Reset (synchronous) returns the registers to their defaults, clears the
// frame state and empties both pipeline stages; payload RAM is not cleared,
// since only entries below the stored length are ever returned.
module crc16_packet_deframer (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // item input
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_mode,
   input  wire logic [7:0]                 req_rx_byte,
   input  wire logic [9:0]                 req_read_index,
   // result output
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_kind,
   output logic [7:0]                      rsp_target_id,
   output logic [7:0]                      rsp_sender_id,
   output logic [7:0]                      rsp_command,
   output logic [cpd_pkg::LEN_W-1:0]       rsp_length,
   output logic [7:0]                      rsp_read_data,
   // register writes
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [1:0]                 csr_index,
   input  wire logic [15:0]                csr_wdata
);

   localparam int LW = cpd_pkg::LEN_W;
   localparam int AW = cpd_pkg::ADDR_W;

   // configuration registers
   logic [7:0]    start_byte_ff;
   logic [15:0]   timeout_ff;
   logic [LW-1:0] max_len_ff;

   // frame state
   cpd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]    hdr_ff [cpd_pkg::HDR_BYTES];
   logic [2:0]    hdr_cnt_ff, hdr_cnt_in;
   logic [LW-1:0] pay_cnt_ff, pay_cnt_in;
   logic [LW-1:0] stored_len_ff, stored_len_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    crc_lo_ff, crc_lo_in;
   logic          crc_cnt_ff, crc_cnt_in;
   logic [15:0]   idle_ff, idle_in;
   logic          hdr_we;

   // pipeline stages
   logic          s1_valid_ff;
   logic [1:0]    s1_kind_ff;
   logic [7:0]    s1_target_ff, s1_sender_ff, s1_command_ff;
   logic [LW-1:0] s1_len_ff;
   logic          s1_hit_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_kind_ff;
   logic [7:0]    rsp_target_ff, rsp_sender_ff, rsp_command_ff, rsp_data_ff;
   logic [LW-1:0] rsp_len_ff;

   // item decode
   logic          accept, is_byte, is_tick, is_read;
   logic          s1_adv;
   logic [15:0]   crc_next;
   logic [15:0]   hdr_len;     // length with the incoming byte as the high byte
   logic [15:0]   frame_len;   // length of the frame in progress
   logic [15:0]   idle_inc;
   logic          too_long;
   logic          crc_done;
   logic          crc_match;
   logic          res_valid;
   logic [1:0]    res_kind;
   logic          rd_hit;
   logic          ram_we;
   logic [7:0]    ram_rdata;

   assign accept  = req_valid && !req_stall;
   assign is_byte = accept && (req_mode == cpd_pkg::MODE_BYTE);
   assign is_tick = accept && (req_mode == cpd_pkg::MODE_TICK);
   assign is_read = accept && (req_mode == cpd_pkg::MODE_READ);

   // advance the middle stage whenever the output register can take it
   assign s1_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign csr_ready = 1'b1;

   assign crc_next  = cpd_pkg::crc_feed(crc_ff, req_rx_byte);
   assign hdr_len   = {req_rx_byte, hdr_ff[3]};
   assign frame_len = {hdr_ff[4], hdr_ff[3]};
   assign idle_inc  = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
   assign too_long  = (hdr_len > {5'd0, max_len_ff})
                   || (hdr_len > 16'(cpd_pkg::PAYLOAD_DEPTH));
   assign crc_done  = is_byte && (phase_ff == cpd_pkg::PH_CRC) && crc_cnt_ff;
   assign crc_match = ({req_rx_byte, crc_lo_ff} == crc_ff);
   assign rd_hit    = {1'b0, req_read_index} < stored_len_ff;

   assign res_valid = crc_done || is_read;
   assign res_kind  = is_read ? cpd_pkg::KIND_READ
                    : (crc_match ? cpd_pkg::KIND_GOOD : cpd_pkg::KIND_CRC_ERR);

   // ---------------- phase: next state ----------------
   always_comb begin
      phase_in = phase_ff;
      if (is_byte) begin
         case (phase_ff)
            cpd_pkg::PH_WAIT: begin
               if (req_rx_byte == start_byte_ff) phase_in = cpd_pkg::PH_HEADER;
            end
            cpd_pkg::PH_HEADER: begin
               if (hdr_cnt_ff == 3'(cpd_pkg::HDR_BYTES - 1)) begin
                  if (too_long) phase_in = cpd_pkg::PH_WAIT;
                  else if (hdr_len == 16'd0) phase_in = cpd_pkg::PH_CRC;
                  else phase_in = cpd_pkg::PH_PAYLOAD;
               end
            end
            cpd_pkg::PH_PAYLOAD: begin
               if ({5'd0, pay_cnt_ff + LW'(1)} >= frame_len) phase_in = cpd_pkg::PH_CRC;
            end
            cpd_pkg::PH_CRC: begin
               if (crc_cnt_ff) phase_in = cpd_pkg::PH_WAIT;
            end
            default: phase_in = cpd_pkg::PH_WAIT;
         endcase
      end else if (is_tick && (phase_ff != cpd_pkg::PH_WAIT) && (idle_inc > timeout_ff)) begin
         phase_in = cpd_pkg::PH_WAIT;
      end
   end

   // ---------------- phase: datapath updates ----------------
   always_comb begin
      hdr_cnt_in    = hdr_cnt_ff;
      pay_cnt_in    = pay_cnt_ff;
      stored_len_in = stored_len_ff;
      crc_in        = crc_ff;
      crc_lo_in     = crc_lo_ff;
      crc_cnt_in    = crc_cnt_ff;
      idle_in       = idle_ff;
      hdr_we        = 1'b0;
      ram_we        = 1'b0;
      if (is_byte) begin
         idle_in = 16'd0;
         case (phase_ff)
            cpd_pkg::PH_WAIT: begin
               if (req_rx_byte == start_byte_ff) begin
                  hdr_cnt_in = 3'd0;
                  crc_in     = cpd_pkg::CRC_INIT;
               end
            end
            cpd_pkg::PH_HEADER: begin
               hdr_we     = 1'b1;
               hdr_cnt_in = hdr_cnt_ff + 3'd1;
               crc_in     = crc_next;
               if (hdr_cnt_ff == 3'(cpd_pkg::HDR_BYTES - 1)) begin
                  pay_cnt_in = '0;
                  crc_cnt_in = 1'b0;
                  if (too_long) begin
                     // drop the frame silently
                     hdr_cnt_in = 3'd0;
                     crc_in     = cpd_pkg::CRC_INIT;
                  end else begin
                     stored_len_in = '0;
                  end
               end
            end
            cpd_pkg::PH_PAYLOAD: begin
               ram_we     = pay_cnt_ff < LW'(cpd_pkg::PAYLOAD_DEPTH);
               pay_cnt_in = pay_cnt_ff + LW'(1);
               crc_in     = crc_next;
               crc_cnt_in = 1'b0;
            end
            cpd_pkg::PH_CRC: begin
               if (!crc_cnt_ff) begin
                  crc_lo_in  = req_rx_byte;
                  crc_cnt_in = 1'b1;
               end else begin
                  if (crc_match) stored_len_in = frame_len[LW-1:0];
                  hdr_cnt_in = 3'd0;
                  pay_cnt_in = '0;
                  crc_cnt_in = 1'b0;
                  crc_in     = cpd_pkg::CRC_INIT;
               end
            end
            default: ;
         endcase
      end else if (is_tick && (phase_ff != cpd_pkg::PH_WAIT)) begin
         idle_in = idle_inc;
         if (idle_inc > timeout_ff) begin
            // idle timeout: drop the partial frame
            hdr_cnt_in = 3'd0;
            pay_cnt_in = '0;
            crc_cnt_in = 1'b0;
            crc_in     = cpd_pkg::CRC_INIT;
            idle_in    = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= cpd_pkg::START_BYTE_RST;
         timeout_ff    <= cpd_pkg::TIMEOUT_RST;
         max_len_ff    <= cpd_pkg::MAX_LEN_RST;
         phase_ff      <= cpd_pkg::PH_WAIT;
         hdr_cnt_ff    <= 3'd0;
         pay_cnt_ff    <= '0;
         stored_len_ff <= '0;
         crc_ff        <= cpd_pkg::CRC_INIT;
         crc_lo_ff     <= 8'd0;
         crc_cnt_ff    <= 1'b0;
         idle_ff       <= 16'd0;
         for (int i = 0; i < cpd_pkg::HDR_BYTES; i++) hdr_ff[i] <= 8'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cpd_pkg::CSR_START_BYTE: start_byte_ff <= csr_wdata[7:0];
               cpd_pkg::CSR_TIMEOUT:    timeout_ff    <= csr_wdata;
               cpd_pkg::CSR_MAX_LENGTH: max_len_ff    <= csr_wdata[LW-1:0];
               default: ;
            endcase
         end
         phase_ff      <= phase_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         pay_cnt_ff    <= pay_cnt_in;
         stored_len_ff <= stored_len_in;
         crc_ff        <= crc_in;
         crc_lo_ff     <= crc_lo_in;
         crc_cnt_ff    <= crc_cnt_in;
         idle_ff       <= idle_in;
         if (hdr_we) hdr_ff[hdr_cnt_ff] <= req_rx_byte;
      end
   end

   // Payload buffer. A read can only hit entries below the stored length,
   // which is zero while a frame is being written, so a write never races
   // a read that returns data.
   cpd_ram #(
      .WIDTH (8),
      .DEPTH (cpd_pkg::PAYLOAD_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pay_cnt_ff[AW-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (is_read),
      .rd_addr (req_read_index[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // Middle stage: holds the result while the RAM read completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= accept && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_kind_ff    <= res_kind;
         s1_target_ff  <= is_read ? 8'd0 : hdr_ff[0];
         s1_sender_ff  <= is_read ? 8'd0 : hdr_ff[1];
         s1_command_ff <= is_read ? 8'd0 : hdr_ff[2];
         s1_len_ff     <= is_read ? stored_len_ff : frame_len[LW-1:0];
         s1_hit_ff     <= is_read && rd_hit;
      end
   end

   // Output register: advance when empty or taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_kind_ff    <= s1_kind_ff;
         rsp_target_ff  <= s1_target_ff;
         rsp_sender_ff  <= s1_sender_ff;
         rsp_command_ff <= s1_command_ff;
         rsp_len_ff     <= s1_len_ff;
         rsp_data_ff    <= s1_hit_ff ? ram_rdata : 8'd0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_target_id = rsp_target_ff;
   assign rsp_sender_id = rsp_sender_ff;
   assign rsp_command   = rsp_command_ff;
   assign rsp_length    = rsp_len_ff;
   assign rsp_read_data = rsp_data_ff;

   // ---------------- assertions ----------------
   // A read that returns data never targets the entry being written.
   a_no_rw_hazard: assert property (@(posedge clock) disable iff (reset)
      (ram_we && is_read && (pay_cnt_ff[AW-1:0] == req_read_index[AW-1:0])) |-> !rd_hit)
      else $error("payload write collides with a live read");

   // A held middle stage issues no new RAM read, so its read data survives.
   a_hold_no_read: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> ((ram_rdata === $past(ram_rdata)) && s1_valid_ff))
      else $error("read data lost while stalled");

   // Stored length never exceeds the buffer.
   a_stored_len: assert property (@(posedge clock) disable iff (reset)
      stored_len_ff <= LW'(cpd_pkg::PAYLOAD_DEPTH))
      else $error("stored length beyond buffer");

   // Header counter stays inside the header while collecting it.
   a_hdr_cnt: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == cpd_pkg::PH_HEADER) |-> (hdr_cnt_ff < 3'(cpd_pkg::HDR_BYTES)))
      else $error("header counter overrun");

endmodule
`default_nettype wire
